// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants and round functions of the byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned CountW = 61;
    localparam logic [7:0]  PadByte = 8'h80;
    localparam logic [5:0]  LenPos = 6'd56;

    typedef logic [31:0] t_word;

    // controller to compression core
    typedef struct packed {
        logic start;
    } t_core_cmd;

    function automatic t_word round_k(input logic [5:0] i);
        t_word k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic t_word ror(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== src/sha_if.sv =====
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels of the byte stream hasher.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       empty_message;
    modport source (output valid, data_byte, last, empty_message, input ready);
    modport sink (input valid, data_byte, last, empty_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// Byte stream SHA-256: packs bytes into a 16-word block memory, pads at the
// end of a message and emits the digest as eight words.
//
//   channel  dir  payload                                   handshake
//   s_in     in   data_byte[8], last, empty_message         valid/ready
//   m_out    out  digest_word[32], word_index[3], last_word valid/ready
//
// a byte is accepted with a store read, then merged and written
// a full block: start, 64 compression rounds, chain update
// message end: read and write the pad word, clear each zero word, write the two
// length words, then a compression; a second block follows when the pad lands at byte 56+
// the digest drains one word a cycle while the receiver is ready
// synchronous active-low reset loads the initial hash and clears the count
// input is held off except while waiting for the next byte
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    s_in,
    sha_out_if.source m_out
);
    import sha_pkg::*;

    typedef enum logic [8:0] {
        S_IN   = 9'b000000001,
        S_RMW  = 9'b000000010,
        S_PRD  = 9'b000000100,
        S_PWR  = 9'b000001000,
        S_ZERO = 9'b000010000,
        S_LEN  = 9'b000100000,
        S_GO   = 9'b001000000,
        S_COMP = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [CountW-1:0] r_cnt;
    logic [5:0]        r_pos;       // byte position being written
    logic [7:0]        r_byte;
    logic              r_last;      // byte in flight ends the message
    logic              r_fin;       // message end in progress
    logic              r_two;       // padding needs a second block
    logic [3:0]        r_zaddr;     // next word to clear
    logic              r_lsel;      // length word select
    logic [2:0]        r_oidx;
    t_word             r_chain [8];
    t_word             mem [16];
    t_word             r_rdata;

    t_core_cmd  cmd;
    logic       core_busy, core_done, core_we, chain_upd;
    logic [3:0] core_raddr, core_waddr;
    t_word      core_wdata;
    t_word      chain_new [8];

    logic       mem_we;
    logic [3:0] mem_waddr, mem_raddr;
    t_word      mem_wdata, byte_word, pad_word;
    logic [3:0] zero_end;
    logic       in_acc, out_acc;

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_busy(core_busy),
        .o_done(core_done), .o_rd_addr(core_raddr), .i_rd_data(r_rdata),
        .o_wr_en(core_we), .o_wr_addr(core_waddr), .o_wr_data(core_wdata),
        .i_chain(r_chain), .o_chain_upd(chain_upd), .o_chain_new(chain_new)
    );

    assign in_acc     = s_in.valid && s_in.ready;
    assign out_acc    = m_out.valid && m_out.ready;
    assign s_in.ready = (r_state == S_IN);
    assign cmd.start  = (r_state == S_GO) && !core_busy;

    // last word to clear in the current padding block
    assign zero_end = r_two ? 4'd15 : 4'd13;

    // merge a message byte into its store word
    always_comb begin
        case (r_pos[1:0])
            2'd0:    byte_word = {r_byte, r_rdata[23:0]};
            2'd1:    byte_word = {r_rdata[31:24], r_byte, r_rdata[15:0]};
            2'd2:    byte_word = {r_rdata[31:16], r_byte, r_rdata[7:0]};
            default: byte_word = {r_rdata[31:8], r_byte};
        endcase
    end

    // pad byte after the message, zeros behind it
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    pad_word = {PadByte, 24'h0};
            2'd1:    pad_word = {r_rdata[31:24], PadByte, 16'h0};
            2'd2:    pad_word = {r_rdata[31:16], PadByte, 8'h0};
            default: pad_word = {r_rdata[31:8], PadByte};
        endcase
    end

    // memory port mux
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = core_waddr;
        mem_wdata = core_wdata;
        mem_raddr = core_raddr;
        case (r_state)
            S_IN:   mem_raddr = r_cnt[5:2];
            S_RMW: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[5:2];
                mem_wdata = byte_word;
            end
            S_PRD:  mem_raddr = r_cnt[5:2];
            S_PWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[5:2];
                mem_wdata = pad_word;
            end
            S_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = r_zaddr;
                mem_wdata = '0;
            end
            S_LEN: begin
                mem_we    = 1'b1;
                mem_waddr = r_lsel ? 4'd15 : 4'd14;
                mem_wdata = r_lsel ? {r_cnt[28:0], 3'b000} : r_cnt[60:29];
            end
            S_COMP: mem_we = core_we;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IN:   if (in_acc) n_state = s_in.empty_message ? S_PRD : S_RMW;
            S_RMW: begin
                if (r_pos == 6'd63) n_state = S_GO;
                else if (r_last) n_state = S_PRD;
                else n_state = S_IN;
            end
            S_PRD:  n_state = S_PWR;
            S_PWR: begin
                if (r_cnt[5:2] == zero_end) n_state = r_two ? S_GO : S_LEN;
                else n_state = S_ZERO;
            end
            S_ZERO: if (r_zaddr == zero_end) n_state = r_two ? S_GO : S_LEN;
            S_LEN:  if (r_lsel) n_state = S_GO;
            S_GO:   if (!core_busy) n_state = S_COMP;
            S_COMP: if (core_done) begin
                if (!r_fin) n_state = r_last ? S_PRD : S_IN;
                else if (r_two) n_state = S_ZERO;
                else n_state = S_OUT;
            end
            S_OUT:  if (out_acc && r_oidx == 3'd7) n_state = S_IN;
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
            r_lsel  <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IN: if (in_acc && !s_in.empty_message) begin
                    r_pos  <= r_cnt[5:0];
                    r_byte <= s_in.data_byte;
                    r_last <= s_in.last;
                    r_cnt  <= r_cnt + {{(CountW-1){1'b0}}, 1'b1};
                end
                S_PRD: begin
                    r_fin  <= 1'b1;
                    r_two  <= (r_cnt[5:0] >= LenPos);
                    r_lsel <= 1'b0;
                end
                S_PWR:  r_zaddr <= r_cnt[5:2] + 4'd1;
                S_ZERO: r_zaddr <= r_zaddr + 4'd1;
                S_LEN:  r_lsel <= ~r_lsel;
                S_COMP: begin
                    if (chain_upd) r_chain <= chain_new;
                    // second padding block starts from word zero
                    if (core_done && r_fin && r_two) begin
                        r_two   <= 1'b0;
                        r_zaddr <= '0;
                    end
                end
                S_OUT: if (out_acc) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_cnt <= '0;
                        r_fin <= 1'b0;
                        for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_out.valid       = (r_state == S_OUT);
    assign m_out.digest_word = r_chain[r_oidx];
    assign m_out.word_index  = r_oidx;
    assign m_out.last_word   = (r_oidx == 3'd7);

endmodule

// ===== src/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// 64-round compression, each round stepping S_RD0, S_RD1, S_RD2, S_RND. The
// message schedule is a 16-word ring in the block memory, read a state ahead of its use.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_cmd i_cmd,
    output logic               o_busy,
    output logic               o_done,
    // block memory port, read data is registered and returns in the next cycle
    output logic [3:0]         o_rd_addr,
    input  sha_pkg::t_word     i_rd_data,
    output logic               o_wr_en,
    output logic [3:0]         o_wr_addr,
    output sha_pkg::t_word     o_wr_data,
    // chaining words
    input  sha_pkg::t_word     i_chain [8],
    output logic               o_chain_upd,
    output sha_pkg::t_word     o_chain_new [8]
);
    import sha_pkg::*;

    // phases: fetch four schedule taps per round (w-16, w-15, w-7, w-2)
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_RD0 = 5'b00010, S_RD1 = 5'b00100,
        S_RD2 = 5'b01000, S_RND = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_rnd;
    t_word       r_wk [8];
    t_word       r_t16, r_t15, r_t7;
    logic        r_done;

    t_word w_cur, s0, s1, t1, t2;
    t_word a, b, c, d, e, f, g, h;

    assign a = r_wk[0]; assign b = r_wk[1]; assign c = r_wk[2]; assign d = r_wk[3];
    assign e = r_wk[4]; assign f = r_wk[5]; assign g = r_wk[6]; assign h = r_wk[7];

    // read address sequence per round
    always_comb begin
        case (r_state)
            S_IDLE:  o_rd_addr = r_rnd[3:0];
            S_RD0:   o_rd_addr = r_rnd[3:0] + 4'd1;
            S_RD1:   o_rd_addr = r_rnd[3:0] + 4'd9;
            S_RD2:   o_rd_addr = r_rnd[3:0] + 4'd14;
            default: o_rd_addr = r_rnd[3:0] + 4'd1;
        endcase
    end

    // schedule word for this round; in S_RND, read data is w-2
    always_comb begin
        s0 = ror(r_t15, 7) ^ ror(r_t15, 18) ^ (r_t15 >> 3);
        s1 = ror(i_rd_data, 17) ^ ror(i_rd_data, 19) ^ (i_rd_data >> 10);
        w_cur = (r_rnd < 6'd16) ? r_t16 : (r_t16 + s0 + r_t7 + s1);
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + round_k(r_rnd) + w_cur;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    end

    assign o_wr_en   = (r_state == S_RND) && (r_rnd >= 6'd16);
    assign o_wr_addr = r_rnd[3:0];
    assign o_wr_data = w_cur;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_cmd.start) n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RND;
            S_RND:   n_state = (r_rnd == 6'd63) ? S_IDLE : S_RD0;
            default: n_state = S_IDLE;
        endcase
    end

    // taps and working words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_RND) && (r_rnd == 6'd63);
            if (r_state == S_RND) r_rnd <= r_rnd + 6'd1;
        end
        if (r_state == S_IDLE && i_cmd.start) r_wk <= i_chain;
        if (r_state == S_RD0) r_t16 <= i_rd_data;
        if (r_state == S_RD1) r_t15 <= i_rd_data;
        if (r_state == S_RD2) r_t7  <= i_rd_data;
        if (r_state == S_RND) begin
            r_wk[7] <= g; r_wk[6] <= f; r_wk[5] <= e; r_wk[4] <= d + t1;
            r_wk[3] <= c; r_wk[2] <= b; r_wk[1] <= a; r_wk[0] <= t1 + t2;
        end
    end

    // chaining update in the cycle after the last round
    always_comb begin
        for (int i = 0; i < 8; i++) o_chain_new[i] = i_chain[i] + r_wk[i];
    end
    assign o_chain_upd = r_done;
    assign o_done      = r_done;
    assign o_busy      = (r_state != S_IDLE) || r_done;

endmodule
